FILE: design/bblg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblg_pkg
// Shared constants and types for the bijective base-k label generator.
// ----------------------------------------------------------------------------
package bblg_pkg;

  localparam int NUMBER_WIDTH  = 50;
  localparam int MAX_LABEL_LEN = 50;
  localparam int ALPHABET_MAX  = 32;

  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 5;
  localparam int CHAR_W      = 8;
  localparam int ALPHA_WORDS = 4;
  localparam int ALPHA_WORD_W = 64;
  localparam int ALPHA_BITS  = ALPHA_WORDS * ALPHA_WORD_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RADIX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_3 = 3'd4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd26;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;

  // Divider: DIV_BITS quotient bits per cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = (NUMBER_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W     = DIV_STEPS * DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int LEN_W  = $clog2(MAX_LABEL_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LABEL_LEN);

  typedef struct packed {
    logic [RADIX_W-1:0]    radix;
    logic [ALPHA_BITS-1:0] alphabet;
  } bblg_cfg_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic step;
    logic store;
    logic rd_issue;
    logic emit;
  } bblg_cmd_t;

  typedef struct packed {
    logic in_zero;
    logic div_last;
    logic quot_zero;
    logic len_full;
    logic rd_last;
    logic out_free;
  } bblg_status_t;

endpackage

FILE: design/bijective_base_label_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bijective_base_label_generator_top
// Turns a label number into its bijective base-k label, one character a beat.
// ----------------------------------------------------------------------------
// One label at a time. After the label is accepted, each character is
// extracted in turn (load, divider steps at 8 quotient bits each over the
// 50-bit number, store), then the digit store is read back most significant
// first, a read and an emit per character, emits waiting on output stall.
// The divider by the radix sets the extraction time. Label number zero is
// taken and gives no beats. Radix is clamped to 2..32.
module bijective_base_label_generator_top import bblg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [NUMBER_WIDTH-1:0] label_number_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CHAR_W-1:0]       label_char_o,
  output logic [DIGIT_W-1:0]      digit_index_o,
  output logic                    last_char_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  bblg_cfg_t    cfg;
  bblg_cmd_t    cmd;
  bblg_status_t status;

  bblg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bblg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bblg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .status_o       (status),
    .label_number_i (label_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .label_char_o   (label_char_o),
    .digit_index_o  (digit_index_o),
    .last_char_o    (last_char_o)
  );

endmodule

FILE: design/bblg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bblg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bblg_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblg_cfg
// Configuration registers: radix (clamped to the legal range) and alphabet.
// ----------------------------------------------------------------------------
module bblg_cfg import bblg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output bblg_cfg_t             cfg_o
);

  logic [RADIX_W-1:0]      radix_q;
  logic [ALPHA_WORD_W-1:0] alpha_q [ALPHA_WORDS];
  logic [RADIX_W-1:0]      radix_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
      for (int i = 0; i < ALPHA_WORDS; i++) begin
        alpha_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RADIX:   radix_q    <= cfg_data_i[RADIX_W-1:0];
        REG_ALPHA_0: alpha_q[0] <= cfg_data_i;
        REG_ALPHA_1: alpha_q[1] <= cfg_data_i;
        REG_ALPHA_2: alpha_q[2] <= cfg_data_i;
        REG_ALPHA_3: alpha_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (radix_q < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_q > RADIX_W'(ALPHABET_MAX)) begin
      radix_eff = RADIX_W'(ALPHABET_MAX);
    end else begin
      radix_eff = radix_q;
    end
  end

  assign cfg_o.radix    = radix_eff;
  assign cfg_o.alphabet = {alpha_q[3], alpha_q[2], alpha_q[1], alpha_q[0]};

endmodule

FILE: design/bblg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblg_dp
// Datapath: iterative divider by the radix, digit store, output register.
// ----------------------------------------------------------------------------
module bblg_dp import bblg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bblg_cfg_t               cfg_i,
  input  bblg_cmd_t               cmd_i,
  output bblg_status_t            status_o,
  input  logic [NUMBER_WIDTH-1:0] label_number_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CHAR_W-1:0]       label_char_o,
  output logic [DIGIT_W-1:0]      digit_index_o,
  output logic                    last_char_o
);

  logic [NUMBER_WIDTH-1:0] num_q;
  logic [DIV_W-1:0]        div_q, div_d;
  logic [RADIX_W-1:0]      rem_q, rem_d;
  logic [STEP_W-1:0]       step_q;
  logic [LEN_W-1:0]        len_q;
  logic [ADDR_W-1:0]       rd_q;
  logic [NUMBER_WIDTH-1:0] num_m1;

  logic                    out_valid_q;
  logic [CHAR_W-1:0]       char_q;
  logic [DIGIT_W-1:0]      digit_q;
  logic                    last_q;
  logic [DIGIT_W-1:0]      ram_rdata;

  assign num_m1 = num_q - NUMBER_WIDTH'(1);

  // DIV_BITS restoring steps; remainder stays below radix (narrow compare)
  always_comb begin
    logic [RADIX_W-1:0] t;
    logic [DIV_W-1:0]   q;
    logic [RADIX_W-1:0] r;
    q = div_q;
    r = rem_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r[RADIX_W-2:0], q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (t >= cfg_i.radix) begin
        t    = t - cfg_i.radix;
        q[0] = 1'b1;
      end
      r = t;
    end
    div_d = q;
    rem_d = r;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      num_q <= label_number_i;
    end else if (cmd_i.store) begin
      num_q <= div_q[NUMBER_WIDTH-1:0];
    end
    if (cmd_i.load) begin
      div_q <= DIV_W'(num_m1);
      rem_q <= '0;
    end else if (cmd_i.step) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      len_q  <= '0;
      rd_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        step_q <= '0;
      end else if (cmd_i.step) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (cmd_i.capture) begin
        len_q <= '0;
      end else if (cmd_i.store) begin
        len_q <= len_q + LEN_W'(1);
      end
      // the digit just stored is the most significant so far
      if (cmd_i.store) begin
        rd_q <= len_q[ADDR_W-1:0];
      end else if (cmd_i.emit) begin
        rd_q <= rd_q - ADDR_W'(1);
      end
    end
  end

  bblg_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_LABEL_LEN)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (len_q[ADDR_W-1:0]),
    .wdata_i (rem_q[DIGIT_W-1:0]),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_q),
    .rdata_o (ram_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_q  <= cfg_i.alphabet[{ram_rdata, 3'b000} +: CHAR_W];
      digit_q <= ram_rdata;
      last_q  <= (rd_q == '0);
    end
  end

  assign status_o.in_zero   = (label_number_i == '0);
  assign status_o.div_last  = (step_q == STEP_W'(DIV_STEPS - 1));
  assign status_o.quot_zero = (div_q == '0);
  assign status_o.len_full  = (len_q == LEN_W'(MAX_LABEL_LEN));
  assign status_o.rd_last   = (rd_q == '0);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign label_char_o  = char_q;
  assign digit_index_o = digit_q;
  assign last_char_o   = last_q;

endmodule

FILE: design/bblg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblg_ctrl
// Sequencer: digit extraction loop, then reverse readout of stored digits.
// ----------------------------------------------------------------------------
module bblg_ctrl import bblg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  bblg_status_t status_i,
  output bblg_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          // label number zero has no label
          if (!status_i.in_zero) begin
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        if (status_i.len_full) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.store = 1'b1;
          state_d     = status_i.quot_zero ? S_READ : S_LOAD;
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.rd_last ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bijective base-k label generator.
// Label numbers are sent under a sweep of radix and alphabet settings, and the
// expected character beats of each label are predicted. The output stream is
// then compared beat by beat, in order. Both sides idle at random, and the
// output side twice holds off for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module testbench;
  import bblg_pkg::*;

  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 600;
  localparam int HOLD_CYCLES   = 1500;
  localparam int HOLD_EVERY    = 40;    // beats between long output hold-offs
  localparam int PHASE_ITEMS   = 19;

  localparam logic [NUMBER_WIDTH-1:0] NUM_MAX = '1;
  localparam logic [NUMBER_WIDTH-1:0] NUM_TOP = NUM_MAX ^ (NUM_MAX >> 1);

  typedef struct packed {
    logic [CHAR_W-1:0]  label_char;
    logic [DIGIT_W-1:0] digit_index;
    logic               last_char;
  } label_beat_t;

  // Predicts the character beats of each accepted label number and checks
  // the output stream against them in order.
  class label_checker;
    logic [RADIX_W-1:0]    radix;
    logic [ALPHA_BITS-1:0] alphabet;
    label_beat_t           expected_chars[$];
    int unsigned           mismatches;

    function new();
      radix      = RADIX_RESET;
      alphabet   = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      int w;
      if (idx == REG_RADIX) begin
        radix = data[RADIX_W-1:0];
      end else if (idx >= REG_ALPHA_0 && idx <= REG_ALPHA_3) begin
        w = int'(idx) - int'(REG_ALPHA_0);
        alphabet[w*ALPHA_WORD_W +: ALPHA_WORD_W] = data;
      end
    endfunction

    function void note_label(logic [NUMBER_WIDTH-1:0] n);
      logic [NUMBER_WIDTH-1:0] rest;
      logic [DIGIT_W-1:0]      digits[$];
      int unsigned             k;
      label_beat_t             beat;
      k = 32'(radix);
      if (k < 32'(RADIX_MIN)) k = 32'(RADIX_MIN);
      if (k > ALPHABET_MAX) k = ALPHABET_MAX;
      rest = n;
      // bijective digits: value 1..k, symbol index value-1, msd ends up first
      while (rest != 0) begin
        rest = rest - 1;
        digits.push_front(DIGIT_W'(rest % k));
        rest = rest / k;
      end
      if (digits.size() > MAX_LABEL_LEN) return;
      foreach (digits[i]) begin
        beat.label_char  = alphabet[digits[i]*CHAR_W +: CHAR_W];
        beat.digit_index = digits[i];
        beat.last_char   = (i == digits.size() - 1);
        expected_chars.insert(expected_chars.size(), beat);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic [DIGIT_W-1:0] idx, logic last);
      label_beat_t exp_beat;
      if (expected_chars.size() == 0) begin
        $error("unexpected beat: label_char %0h digit_index %0d last_char %0b", ch, idx, last);
        mismatches++;
        return;
      end
      exp_beat = expected_chars.pop_front();
      if (ch !== exp_beat.label_char) begin
        $error("label_char: expected %0h, got %0h", exp_beat.label_char, ch);
        mismatches++;
      end
      if (idx !== exp_beat.digit_index) begin
        $error("digit_index: expected %0d, got %0d", exp_beat.digit_index, idx);
        mismatches++;
      end
      if (last !== exp_beat.last_char) begin
        $error("last_char: expected %0b, got %0b", exp_beat.last_char, last);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_chars.size();
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [NUMBER_WIDTH-1:0] label_number_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [CHAR_W-1:0]       label_char_o;
  logic [DIGIT_W-1:0]      digit_index_o;
  logic                    last_char_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;

  label_checker labels;
  int unsigned  quiet_cycles = 0;
  int unsigned  sender_calm  = 0;
  int unsigned  sink_calm    = 0;

  bijective_base_label_generator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .label_number_i (label_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .label_char_o   (label_char_o),
    .digit_index_o  (digit_index_o),
    .last_char_o    (last_char_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Runs of zero gaps now and then, otherwise a random idle gap before each item
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [NUMBER_WIDTH-1:0] draw_label();
    logic [NUMBER_WIDTH-1:0] n;
    int unsigned             w;
    n = NUMBER_WIDTH'({$urandom(), $urandom()});
    case ($urandom_range(0, 15))
      0: n = '0;
      1: n = NUM_MAX;
      2, 3, 4: ;                    // full width: longest labels
      default: begin
        w = $urandom_range(1, 20);
        n = n & ((NUM_TOP << 1) - 1 >> (NUMBER_WIDTH - w));
      end
    endcase
    return n;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] draw_alpha_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // All tasks start and end at a falling edge
  task automatic send_label(logic [NUMBER_WIDTH-1:0] n);
    int unsigned gap;
    gap = draw_gap(sender_calm);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    label_number_i = n;
    do @(posedge clk_i); while (in_stall_o);
    labels.note_label(n);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    labels.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Zero-length labels leave no beat behind, so settle after the last beat
  task automatic wait_idle();
    while (labels.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic program_regs(logic [RADIX_W-1:0] r);
    logic [CFG_DATA_W-1:0] data;
    data = {$urandom(), $urandom()};
    data[RADIX_W-1:0] = r;
    cfg_write(REG_RADIX, data);
    for (int w = 0; w < ALPHA_WORDS; w++) begin
      cfg_write(REG_ALPHA_0 + CFG_IDX_W'(w), draw_alpha_word());
    end
    // indexes past the register list must be dropped
    if ($urandom_range(0, 2) == 0)
      cfg_write(REG_ALPHA_3 + CFG_IDX_W'($urandom_range(1, 3)), {$urandom(), $urandom()});
  endtask

  initial begin : beat_sink
    int unsigned gap;
    int unsigned beats;
    beats       = 0;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_gap(sink_calm);
      if (gap != 0) begin
        out_stall_i = 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      labels.check_char(label_char_o, digit_index_o, last_char_o);
      beats++;
      @(negedge clk_i);
      // long hold-off so the block fills up and stalls its input
      if (beats % HOLD_EVERY == 0 && beats <= 2 * HOLD_EVERY) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [NUMBER_WIDTH-1:0] reset_set[6];
    logic [NUMBER_WIDTH-1:0] binary_set[7];
    logic [NUMBER_WIDTH-1:0] wide_set[6];
    logic [NUMBER_WIDTH-1:0] clamp_set[3];
    logic [RADIX_W-1:0]      sweep[10];
    logic [RADIX_W-1:0]      r;

    reset_set  = '{1, 26, 27, 702, 703, NUM_MAX};
    binary_set = '{1, 2, 3, NUM_MAX, NUM_TOP, 50'h2AAAAAAAAAAAA, 50'h1555555555555};
    wide_set   = '{1, 32, 33, 1057, NUM_MAX, 0};
    clamp_set  = '{0, 2, 3};
    sweep      = '{2, 32, 26, 10, 0, 1, 33, 63, 3, 17};

    labels         = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    label_number_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: radix 26, all-zero alphabet
    foreach (reset_set[i]) send_label(reset_set[i]);
    send_label('0);
    wait_idle();

    cfg_write(REG_RADIX, CFG_DATA_W'(RADIX_MIN));
    for (int w = 0; w < ALPHA_WORDS; w++) cfg_write(REG_ALPHA_0 + CFG_IDX_W'(w), '1);
    foreach (binary_set[i]) send_label(binary_set[i]);
    wait_idle();

    cfg_write(REG_RADIX, CFG_DATA_W'(ALPHABET_MAX));
    for (int w = 0; w < ALPHA_WORDS; w++) begin
      cfg_write(REG_ALPHA_0 + CFG_IDX_W'(w), {$urandom(), $urandom()});
    end
    foreach (wide_set[i]) send_label(wide_set[i]);
    wait_idle();

    // below-range radix acts as 2, above-range as 32
    cfg_write(REG_RADIX, '0);
    foreach (clamp_set[i]) send_label(clamp_set[i]);
    wait_idle();
    cfg_write(REG_RADIX, '1);
    send_label(NUMBER_WIDTH'(32));
    send_label(NUMBER_WIDTH'(33));
    wait_idle();

    for (int p = 0; p <= $size(sweep); p++) begin
      r = (p == $size(sweep)) ? RADIX_W'($urandom_range(2, 32)) : sweep[p];
      program_regs(r);
      repeat (PHASE_ITEMS) send_label(draw_label());
      wait_idle();
    end

    if (labels.mismatches == 0 && labels.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
